// ===== rtl/core/bounded_deque_with_positional_remove_unit_macros.svh =====
// Assertion macros shared by the deque checker
`ifndef BOUNDED_DEQUE_WITH_POSITIONAL_REMOVE_UNIT_MACROS_SVH
`define BOUNDED_DEQUE_WITH_POSITIONAL_REMOVE_UNIT_MACROS_SVH

// Same-cycle implication, disabled while reset is asserted
`define BDQ_ASSERT_NOW(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("deque check failed: same-cycle rule");

// Next-cycle implication, disabled while reset is asserted
`define BDQ_ASSERT_NEXT(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("deque check failed: next-cycle rule");

`endif

// ===== rtl/core/bdq_pkg.sv =====
// Package with types, sizes and action codes of the bounded deque
`timescale 1ns / 1ps
package bdq_pkg;

    localparam int DEPTH         = 16;
    localparam int DATA_W        = 32;
    localparam int AW            = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CW            = $clog2(DEPTH + 1);
    localparam int ACTION_W      = 3;
    localparam int PAYLOAD_W     = 32;
    localparam int POS_W         = 5;
    localparam int RES_DATA_W    = 32;
    localparam int RES_COUNT_W   = 5;
    localparam int XW            = (CW > POS_W) ? CW : POS_W;

    localparam logic [ACTION_W-1:0] ACT_PUSH_FRONT = 3'd0;
    localparam logic [ACTION_W-1:0] ACT_PUSH_BACK  = 3'd1;
    localparam logic [ACTION_W-1:0] ACT_POP_FRONT  = 3'd2;
    localparam logic [ACTION_W-1:0] ACT_POP_BACK   = 3'd3;
    localparam logic [ACTION_W-1:0] ACT_PEEK_FRONT = 3'd4;
    localparam logic [ACTION_W-1:0] ACT_PEEK_BACK  = 3'd5;
    localparam logic [ACTION_W-1:0] ACT_REMOVE_AT  = 3'd6;

    typedef struct packed {
        logic [ACTION_W-1:0]  action;
        logic [PAYLOAD_W-1:0] payload;
        logic [POS_W-1:0]     position;
    } t_cmd;

    typedef struct packed {
        logic [RES_DATA_W-1:0]  data;
        logic                   ok;
        logic [RES_COUNT_W-1:0] count;
    } t_result;

endpackage

// ===== rtl/core/bdq_ram.sv =====
// Simple dual-port entry store with registered read data
`timescale 1ns / 1ps
module bdq_ram #(
    parameter int ADDR_W = 4,
    parameter int WORD_W = 32
) (
    input  logic              i_clk,
    input  logic              i_we,
    input  logic [ADDR_W-1:0] i_waddr,
    input  logic [WORD_W-1:0] i_wdata,
    input  logic [ADDR_W-1:0] i_raddr,
    output logic [WORD_W-1:0] o_rdata
);

    logic [WORD_W-1:0] r_mem [2**ADDR_W];
    logic [WORD_W-1:0] r_rdata;

    // write port
    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
    end

    // read port, registered read data
    always_ff @(posedge i_clk) begin
        r_rdata <= r_mem[i_raddr];
    end

    assign o_rdata = r_rdata;

endmodule

// ===== rtl/core/bounded_deque_with_positional_remove_unit.sv =====
// A push or a failed command strobes its result in the cycle after acceptance.
// Pop and peek strobe after one entry-store read: the registered read data goes to the result register.
// Remove at position reads the entry there, then moves each later entry toward the front: one store move per cycle.
// busy stays high until the result strobe; the receiver cannot stall results.
// Reset (synchronous, active low) empties the deque; the entry store is not cleared.
`timescale 1ns / 1ps
module bounded_deque_with_positional_remove_unit
    import bdq_pkg::*;
(
    input  logic    i_clk,
    input  logic    i_rst_n,
    input  logic    start,
    input  t_cmd    i_cmd,
    output logic    busy,
    output logic    o_done,
    output t_result o_result
);

    typedef enum logic [1:0] {
        S_IDLE,
        S_READ,
        S_SHIFT
    } t_state;

    t_state          r_state, n_state;
    logic [AW-1:0]   r_head, n_head;
    logic [CW-1:0]   r_count, n_count;
    logic            r_remove, n_remove;
    logic [AW-1:0]   r_wr_ptr, n_wr_ptr;
    logic [AW-1:0]   r_rd_ptr, n_rd_ptr;
    logic [CW-1:0]   r_left, n_left;
    logic [DATA_W-1:0] r_data, n_data;
    logic            r_done, n_done;
    t_result         r_result, n_result;

    logic              mem_we;
    logic [AW-1:0]     mem_waddr;
    logic [DATA_W-1:0] mem_wdata;
    logic [AW-1:0]     mem_raddr;
    logic [DATA_W-1:0] mem_rdata;

    logic [DATA_W-1:0] word;
    logic [XW-1:0]     pos_x;
    logic [XW-1:0]     count_x;
    logic              pos_ok;
    logic [CW-1:0]     at_idx;

    // step a physical address forward with wrap
    function automatic logic [AW-1:0] ptr_inc(input logic [AW-1:0] p);
        logic [AW-1:0] r;
        if (p == AW'(DEPTH - 1)) r = '0;
        else                     r = p + 1'b1;
        return r;
    endfunction

    // step a physical address backward with wrap
    function automatic logic [AW-1:0] ptr_dec(input logic [AW-1:0] p);
        logic [AW-1:0] r;
        if (p == '0) r = AW'(DEPTH - 1);
        else         r = p - 1'b1;
        return r;
    endfunction

    // map a logical index from the front to a physical address
    function automatic logic [AW-1:0] phys(input logic [AW-1:0] h, input logic [CW-1:0] idx);
        logic [CW:0] s;
        s = (CW+1)'(h) + (CW+1)'(idx);
        if (s >= (CW+1)'(DEPTH)) s = s - (CW+1)'(DEPTH);
        return AW'(s);
    endfunction

    // build a result transaction
    function automatic t_result mk_result(input logic [DATA_W-1:0] d, input logic ok,
                                          input logic [CW-1:0] c);
        t_result r;
        r.data  = RES_DATA_W'(d);
        r.ok    = ok;
        r.count = RES_COUNT_W'(c);
        return r;
    endfunction

    bdq_ram #(
        .ADDR_W (AW),
        .WORD_W (DATA_W)
    ) u_ram (
        .i_clk   (i_clk),
        .i_we    (mem_we),
        .i_waddr (mem_waddr),
        .i_wdata (mem_wdata),
        .i_raddr (mem_raddr),
        .o_rdata (mem_rdata)
    );

    assign word    = DATA_W'(i_cmd.payload);
    assign pos_x   = XW'(i_cmd.position);
    assign count_x = XW'(r_count);
    assign pos_ok  = (pos_x != '0) && (pos_x <= count_x);
    assign at_idx  = CW'(pos_x - 1'b1);

    // decode commands and sequence store accesses
    always_comb begin
        n_state   = r_state;
        n_head    = r_head;
        n_count   = r_count;
        n_remove  = r_remove;
        n_wr_ptr  = r_wr_ptr;
        n_rd_ptr  = r_rd_ptr;
        n_left    = r_left;
        n_data    = r_data;
        n_done    = 1'b0;
        n_result  = r_result;
        mem_we    = 1'b0;
        mem_waddr = r_wr_ptr;
        mem_wdata = mem_rdata;
        mem_raddr = r_head;

        unique case (r_state)
            S_IDLE: begin
                if (start) begin
                    n_done   = 1'b1;
                    n_result = mk_result('0, 1'b0, r_count);
                    n_remove = 1'b0;
                    unique case (i_cmd.action)
                        ACT_PUSH_FRONT: begin
                            if (r_count < CW'(DEPTH)) begin
                                mem_we    = 1'b1;
                                mem_waddr = ptr_dec(r_head);
                                mem_wdata = word;
                                n_head    = ptr_dec(r_head);
                                n_count   = r_count + 1'b1;
                                n_result  = mk_result('0, 1'b1, r_count + 1'b1);
                            end
                        end
                        ACT_PUSH_BACK: begin
                            if (r_count < CW'(DEPTH)) begin
                                mem_we    = 1'b1;
                                mem_waddr = phys(r_head, r_count);
                                mem_wdata = word;
                                n_count   = r_count + 1'b1;
                                n_result  = mk_result('0, 1'b1, r_count + 1'b1);
                            end
                        end
                        ACT_POP_FRONT, ACT_PEEK_FRONT: begin
                            if (r_count != '0) begin
                                n_done    = 1'b0;
                                mem_raddr = r_head;
                                n_state   = S_READ;
                                if (i_cmd.action == ACT_POP_FRONT) begin
                                    n_head  = ptr_inc(r_head);
                                    n_count = r_count - 1'b1;
                                end
                            end
                        end
                        ACT_POP_BACK, ACT_PEEK_BACK: begin
                            if (r_count != '0) begin
                                n_done    = 1'b0;
                                mem_raddr = phys(r_head, r_count - 1'b1);
                                n_state   = S_READ;
                                if (i_cmd.action == ACT_POP_BACK) begin
                                    n_count = r_count - 1'b1;
                                end
                            end
                        end
                        ACT_REMOVE_AT: begin
                            if (pos_ok) begin
                                n_done    = 1'b0;
                                mem_raddr = phys(r_head, at_idx);
                                n_wr_ptr  = phys(r_head, at_idx);
                                n_left    = CW'(count_x - pos_x);
                                n_remove  = 1'b1;
                                n_state   = S_READ;
                            end
                        end
                        default: begin
                        end
                    endcase
                end
            end
            S_READ: begin
                // word for the result arrives from the store
                if (!r_remove) begin
                    n_done   = 1'b1;
                    n_result = mk_result(mem_rdata, 1'b1, r_count);
                    n_state  = S_IDLE;
                end else if (r_left == '0) begin
                    n_done   = 1'b1;
                    n_result = mk_result(mem_rdata, 1'b1, r_count - 1'b1);
                    n_count  = r_count - 1'b1;
                    n_state  = S_IDLE;
                end else begin
                    n_data    = mem_rdata;
                    mem_raddr = ptr_inc(r_wr_ptr);
                    n_rd_ptr  = ptr_inc(r_wr_ptr);
                    n_state   = S_SHIFT;
                end
            end
            S_SHIFT: begin
                // move one entry toward the front each cycle, reads run one ahead
                mem_we    = 1'b1;
                mem_waddr = r_wr_ptr;
                mem_wdata = mem_rdata;
                n_wr_ptr  = ptr_inc(r_wr_ptr);
                n_left    = r_left - 1'b1;
                mem_raddr = ptr_inc(r_rd_ptr);
                n_rd_ptr  = ptr_inc(r_rd_ptr);
                if (r_left == CW'(1)) begin
                    n_done   = 1'b1;
                    n_result = mk_result(r_data, 1'b1, r_count - 1'b1);
                    n_count  = r_count - 1'b1;
                    n_state  = S_IDLE;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    // hold state, pointers and the registered result
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state  <= S_IDLE;
            r_head   <= '0;
            r_count  <= '0;
            r_remove <= 1'b0;
            r_left   <= '0;
            r_done   <= 1'b0;
        end else begin
            r_state  <= n_state;
            r_head   <= n_head;
            r_count  <= n_count;
            r_remove <= n_remove;
            r_left   <= n_left;
            r_done   <= n_done;
        end
        r_wr_ptr <= n_wr_ptr;
        r_rd_ptr <= n_rd_ptr;
        r_data   <= n_data;
        r_result <= n_result;
    end

    assign busy     = (r_state != S_IDLE);
    assign o_done   = r_done;
    assign o_result = r_result;

endmodule

// ===== rtl/core/bdq_checker.sv =====
// Port-level checker for the bounded deque, bound to the top level
`timescale 1ns / 1ps
`include "bounded_deque_with_positional_remove_unit_macros.svh"
module bdq_checker
    import bdq_pkg::*;
(
    input logic    i_clk,
    input logic    i_rst_n,
    input logic    start,
    input t_cmd    i_cmd,
    input logic    busy,
    input logic    o_done,
    input t_result o_result
);

    // failed transactions carry zero data
    `BDQ_ASSERT_NOW(a_fail_zero, i_clk, i_rst_n, o_done && !o_result.ok, o_result.data == '0)

    // count never exceeds the store depth
    `BDQ_ASSERT_NOW(a_count_max, i_clk, i_rst_n, o_done, o_result.count <= RES_COUNT_W'(DEPTH))

    // the result strobe ends the busy period
    `BDQ_ASSERT_NOW(a_done_idle, i_clk, i_rst_n, o_done, !busy)

    // an accepted transaction either completes at once or holds busy
    `BDQ_ASSERT_NEXT(a_accept_prog, i_clk, i_rst_n, start && !busy, o_done || busy)

endmodule

bind bounded_deque_with_positional_remove_unit bdq_checker u_bdq_checker (.*);
